// ===== rtl/dsrt_pkg.sv =====
package dsrt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int CODE_W   = 40;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int POSTAL_W = 17;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_RANGE  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // year in the top bits so that a plain compare orders dates
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        date_t               date;
        logic [POSTAL_W-1:0] postal;
    } rec_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        rec_t                rec;
        logic                last;
    } out_word_t;

endpackage

// ===== rtl/dsrt_in_if.sv =====
interface dsrt_in_if
    import dsrt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [CODE_W-1:0]   code;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [POSTAL_W-1:0] postal;
    logic [DAY_W-1:0]    end_day;
    logic [MONTH_W-1:0]  end_month;
    logic [YEAR_W-1:0]   end_year;

    modport source (
        output valid, op, code, day, month, year, postal, end_day, end_month, end_year,
        input  ready
    );

    modport sink (
        input  valid, op, code, day, month, year, postal, end_day, end_month, end_year,
        output ready
    );
endinterface

// ===== rtl/dsrt_out_if.sv =====
interface dsrt_out_if
    import dsrt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   rec_code;
    logic [DAY_W-1:0]    rec_day;
    logic [MONTH_W-1:0]  rec_month;
    logic [YEAR_W-1:0]   rec_year;
    logic [POSTAL_W-1:0] rec_postal;
    logic                last;

    modport source (
        output valid, status, rec_code, rec_day, rec_month, rec_year, rec_postal, last,
        input  ready
    );

    modport sink (
        input  valid, status, rec_code, rec_day, rec_month, rec_year, rec_postal, last,
        output ready
    );
endinterface

// ===== rtl/date_sorted_record_table.sv =====
// date-sorted record table, up to CAPACITY records kept latest date first
// req channel: one command word (insert, find, delete by code, range delete, dump)
// rsp channel: result words, each with a status and a record; last marks the
// final word of a command
// one command at a time: req.ready is high only while the table is idle
// a command walks the stored records through one memory read port, one record
// per cycle while the rsp side does not stall, with one date/code compare unit;
// an insert into a full table skips the walk and answers with the full status
// records found, removed or dumped leave in walk order; one word is
// held back so the last mark can be set at the end of the walk
// a stalled rsp side freezes the walk; the output register lets the table
// finish and take the next command while the final word still waits
// reset empties the table (fill count zero) and drops any pending word; the
// record memory itself is not cleared
module date_sorted_record_table
    import dsrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dsrt_in_if.sink    req,
    dsrt_out_if.source rsp
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_TAIL   = 5'b00100,
        S_FINISH = 5'b01000,
        S_SPARE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    date_t               lo_reg, lo_next;
    date_t               hi_reg, hi_next;
    rec_t                carry_reg, carry_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]    ev_idx_reg, ev_idx_next;
    logic [CNT_W-1:0]    w_reg, w_next;
    logic                hit_reg, hit_next;
    logic                pend_valid_reg, pend_valid_next;
    rec_t                pend_reg, pend_next;
    logic [STATUS_W-1:0] fin_status_reg, fin_status_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_reg, out_next;

    rec_t             mem [CAPACITY];
    rec_t             q_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;

    date_t d1, d2;
    logic  accept;
    logic  can_load;
    logic  code_eq, in_range, ins_here;
    logic  match, emit, keep, stall;

    assign d1 = '{year: req.year, month: req.month, day: req.day};
    assign d2 = '{year: req.end_year, month: req.end_month, day: req.end_day};

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && (state_reg == S_IDLE);
    assign can_load  = !out_valid_reg || rsp.ready;

    // shared compare unit on the record under evaluation
    assign code_eq  = (q_reg.code == code_reg);
    assign in_range = (q_reg.date >= lo_reg) && (q_reg.date <= hi_reg);
    // the front place needs a strictly later date, later places a date not earlier
    assign ins_here = (ev_idx_reg == '0) ? (lo_reg > q_reg.date) : (lo_reg >= q_reg.date);

    always_comb
    begin
        match = 1'b0;
        emit  = 1'b0;
        keep  = 1'b1;
        case (op_reg)
            OP_FIND:
            begin
                match = !hit_reg && code_eq;
                emit  = match;
            end
            OP_DELETE:
            begin
                match = !hit_reg && code_eq;
                emit  = match;
                keep  = !match;
            end
            OP_RANGE:
            begin
                match = in_range;
                emit  = match;
                keep  = !match;
            end
            OP_DUMP:
            begin
                match = 1'b1;
                emit  = 1'b1;
            end
            default:
            begin
                match = ins_here;
            end
        endcase
    end

    assign stall = ev_valid_reg && emit && pend_valid_reg && !can_load;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        code_next       = code_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        carry_next      = carry_reg;
        fill_next       = fill_reg;
        rd_ptr_next     = rd_ptr_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        w_next          = w_reg;
        hit_next        = hit_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        fin_status_next = fin_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_next        = out_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_ptr_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = w_reg[IDX_W-1:0];
        wr_data         = q_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.op;
                    code_next       = req.code;
                    carry_next      = '{code: req.code, date: d1, postal: req.postal};
                    lo_next         = d1;
                    hi_next         = d2;
                    if (req.op == OP_RANGE && d1 > d2)
                    begin
                        lo_next = d2;
                        hi_next = d1;
                    end
                    rd_ptr_next     = '0;
                    ev_valid_next   = 1'b0;
                    w_next          = '0;
                    hit_next        = 1'b0;
                    pend_valid_next = 1'b0;
                    fin_status_next = (req.op == OP_INSERT) ? ST_OK : ST_NONE;
                    if (req.op == OP_INSERT && fill_reg == CNT_W'(CAPACITY))
                    begin
                        fin_status_next = ST_FULL;
                        state_next      = S_FINISH;
                    end
                    else if (req.op <= OP_DUMP)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    if (ev_valid_reg)
                    begin
                        if (op_reg == OP_INSERT)
                        begin
                            // once placed, each record moves up one place
                            if (hit_reg || match)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = ev_idx_reg;
                                wr_data    = carry_reg;
                                carry_next = q_reg;
                                hit_next   = 1'b1;
                            end
                        end
                        else
                        begin
                            if (match)
                            begin
                                hit_next = 1'b1;
                            end
                            if (emit)
                            begin
                                pend_valid_next = 1'b1;
                                pend_next       = q_reg;
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next       = '{status: ST_OK, rec: pend_reg, last: 1'b0};
                                end
                            end
                            // compaction for the removing commands
                            if ((op_reg == OP_DELETE || op_reg == OP_RANGE) && keep)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = w_reg[IDX_W-1:0];
                                wr_data = q_reg;
                                w_next  = w_reg + CNT_W'(1);
                            end
                        end
                    end

                    if (rd_ptr_reg < fill_reg)
                    begin
                        rd_en         = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = rd_ptr_reg[IDX_W-1:0];
                        rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                        if (!ev_valid_reg)
                        begin
                            if (op_reg == OP_INSERT)
                            begin
                                state_next = S_TAIL;
                            end
                            else
                            begin
                                if (op_reg == OP_DELETE || op_reg == OP_RANGE)
                                begin
                                    fill_next = w_reg;
                                end
                                state_next = S_FINISH;
                            end
                        end
                    end
                end
            end

            S_TAIL:
            begin
                // new record at the end, or the record pushed off the end
                wr_en      = 1'b1;
                wr_addr    = fill_reg[IDX_W-1:0];
                wr_data    = carry_reg;
                fill_next  = fill_reg + CNT_W'(1);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        out_next = '{status: ST_OK, rec: pend_reg, last: 1'b1};
                    end
                    else
                    begin
                        out_next = '{status: fin_status_reg, rec: '0, last: 1'b1};
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_INSERT;
            fill_reg       <= '0;
            rd_ptr_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            ev_idx_reg     <= '0;
            w_reg          <= '0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            fin_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            fill_reg       <= fill_next;
            rd_ptr_reg     <= rd_ptr_next;
            ev_valid_reg   <= ev_valid_next;
            ev_idx_reg     <= ev_idx_next;
            w_reg          <= w_next;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            fin_status_reg <= fin_status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        carry_reg <= carry_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    // record memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.rec_code   = out_reg.rec.code;
    assign rsp.rec_day    = out_reg.rec.date.day;
    assign rsp.rec_month  = out_reg.rec.date.month;
    assign rsp.rec_year   = out_reg.rec.date.year;
    assign rsp.rec_postal = out_reg.rec.postal;
    assign rsp.last       = out_reg.last;

endmodule
